### rtl/core/bitmap_range_fill_run_counter_macros.svh
// Assertion macros for the bitmap range fill run counter.
// Included by the top level; no other dependencies.
`ifndef BITMAP_RANGE_FILL_RUN_COUNTER_MACROS_SVH
`define BITMAP_RANGE_FILL_RUN_COUNTER_MACROS_SVH
`ifndef SYNTH
`define BMRF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmrf: implication check failed");
`define BMRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmrf: next-cycle check failed");
`else
`define BMRF_ASSERT_IMPL(label, ante, cons)
`define BMRF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/bmrf_pkg.sv
// Shared types and constants for the bitmap range fill run counter.
// No dependencies.
package bmrf_pkg;

    localparam int CFG_W = 11;
    localparam int IDX_W = 10;
    localparam int RUN_W = 10;
    localparam logic [CFG_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } bmrf_state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic walk_step;
    } bmrf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic range_empty;
        logic walk_last;
        logic pipe_busy;
    } bmrf_status_t;

endpackage

### rtl/core/bmrf_ctrl.sv
// Controller state machine for the bitmap range fill run counter.
// Depends on bmrf_pkg for the state, command and status types.
module bmrf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bmrf_pkg::bmrf_status_t status,
    output bmrf_pkg::bmrf_cmd_t    cmd,
    output logic                  busy,
    output logic                  done
);
    import bmrf_pkg::*;

    bmrf_state_t state_reg;
    bmrf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = status.range_empty ? ST_DONE : ST_WALK;
            end
            ST_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_PREP:
            begin
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/bmrf_datapath.sv
// Datapath of the bitmap range fill run counter: bitmap memory, word walker,
// fill and popcount pipeline, running totals. Depends on bmrf_pkg.
module bmrf_datapath #(
    parameter int BITS      = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bmrf_pkg::bmrf_cmd_t                 cmd,
    output bmrf_pkg::bmrf_status_t              status,
    input  logic                                active_length_we,
    input  logic [bmrf_pkg::CFG_W-1:0]          active_length,
    input  logic [bmrf_pkg::IDX_W-1:0]          first_index,
    input  logic [bmrf_pkg::IDX_W-1:0]          last_index,
    input  logic                                fill_value,
    output logic [bmrf_pkg::RUN_W-1:0]          run_count
);
    import bmrf_pkg::*;

    localparam int NWORDS    = (BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL_POS = NWORDS * WORD_BITS;
    localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CW        = $clog2(TOTAL_POS + 1);
    localparam int EW        = (CW > CFG_W) ? CW : CFG_W;
    localparam int RW        = (CW > RUN_W) ? CW : RUN_W;
    localparam int LW        = $clog2(WORD_BITS);
    localparam int PCW       = $clog2(WORD_BITS + 1);

    // Popcount as eight byte counts followed by their sum.
    function automatic logic [6:0] pop64(input logic [63:0] w);
        logic [6:0] total;
        logic [3:0] part;
        total = '0;
        for (int b = 0; b < 8; b++)
        begin
            part = '0;
            for (int i = 0; i < 8; i++)
            begin
                part = part + 4'(w[8*b+i]);
            end
            total = total + 7'(part);
        end
        return total;
    endfunction

    logic [WORD_BITS-1:0] mem [NWORDS];

    logic [CFG_W-1:0]     active_length_reg;
    logic [EW-1:0]        first_reg;
    logic [EW-1:0]        last_reg;
    logic                 fill_reg;
    logic                 empty_reg;
    logic [AW-1:0]        word_reg;
    logic [EW-1:0]        wbase_reg;

    logic                 v1_reg;
    logic                 first1_reg;
    logic [AW-1:0]        addr1_reg;
    logic [WORD_BITS-1:0] mask1_reg;
    logic [WORD_BITS-1:0] rdata_reg;

    logic                 v2_reg;
    logic                 first2_reg;
    logic [WORD_BITS-1:0] old2_reg;
    logic [WORD_BITS-1:0] new2_reg;

    logic                 v3_reg;
    logic [PCW-1:0]       ones_new_reg;
    logic [PCW-1:0]       ones_old_reg;
    logic [PCW-1:0]       pair_new_reg;
    logic [PCW-1:0]       pair_old_reg;

    logic                 old_top_reg;
    logic                 new_top_reg;
    logic [CW-1:0]        ones_reg;
    logic [CW-1:0]        pairs_reg;

    // Clamping of the incoming range to the active length.
    logic [EW-1:0] len_raw;
    logic [EW-1:0] len_eff;
    logic [EW-1:0] first_ext;
    logic [EW-1:0] last_ext;
    logic [EW-1:0] last_clamped;

    always_comb
    begin
        len_raw   = EW'(active_length_reg);
        first_ext = EW'(first_index);
        last_ext  = EW'(last_index);
        if (len_raw == '0)
        begin
            len_eff = EW'(1);
        end
        else if (len_raw > EW'(BITS))
        begin
            len_eff = EW'(BITS);
        end
        else
        begin
            len_eff = len_raw;
        end
        last_clamped = (last_ext > len_eff - EW'(1)) ? (len_eff - EW'(1)) : last_ext;
    end

    // Span mask of the word at the walker position.
    logic [EW-1:0]        wend;
    logic [EW-1:0]        lo_diff;
    logic [EW-1:0]        hi_diff;
    logic [LW-1:0]        lo;
    logic [LW-1:0]        hi;
    logic                 touched;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] all_ones;

    always_comb
    begin
        all_ones = '1;
        wend     = wbase_reg + EW'(WORD_BITS - 1);
        lo_diff  = first_reg - wbase_reg;
        hi_diff  = last_reg - wbase_reg;
        lo       = (first_reg > wbase_reg) ? lo_diff[LW-1:0] : '0;
        hi       = (last_reg < wend) ? hi_diff[LW-1:0] : LW'(WORD_BITS - 1);
        touched  = !empty_reg && (wbase_reg <= last_reg) && (first_reg <= wend);
        word_mask = touched
            ? ((all_ones >> (LW'(WORD_BITS - 1) - hi)) & (all_ones << lo)) : '0;
    end

    logic [WORD_BITS-1:0] fill_word;
    assign fill_word = fill_reg ? (rdata_reg | mask1_reg) : (rdata_reg & ~mask1_reg);

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    always_comb
    begin
        mem_we    = cmd.clear_step || v1_reg;
        mem_waddr = cmd.clear_step ? word_reg : addr1_reg;
        mem_wdata = cmd.clear_step ? '0 : fill_word;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.walk_step)
        begin
            rdata_reg <= mem[word_reg];
        end
    end

    // Stage two: counts of ones and of one-one pairs, old and new word. The
    // pair across the boundary with the previous word is folded in here.
    logic [6:0] pop_on;
    logic [6:0] pop_oo;
    logic [6:0] pop_pn;
    logic [6:0] pop_po;
    logic       bnd_new;
    logic       bnd_old;

    always_comb
    begin
        pop_on  = pop64(64'(new2_reg));
        pop_oo  = pop64(64'(old2_reg));
        pop_pn  = pop64(64'(new2_reg & (new2_reg >> 1)));
        pop_po  = pop64(64'(old2_reg & (old2_reg >> 1)));
        bnd_new = !first2_reg && new_top_reg && new2_reg[0];
        bnd_old = !first2_reg && old_top_reg && old2_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg <= first_ext;
            last_reg  <= last_clamped;
            fill_reg  <= fill_value;
            empty_reg <= first_ext > last_clamped;
        end
        if (cmd.walk_step)
        begin
            mask1_reg  <= word_mask;
            addr1_reg  <= word_reg;
            first1_reg <= (word_reg == '0);
        end
        if (v1_reg)
        begin
            old2_reg   <= rdata_reg;
            new2_reg   <= fill_word;
            first2_reg <= first1_reg;
        end
        if (v2_reg)
        begin
            ones_new_reg <= PCW'(pop_on);
            ones_old_reg <= PCW'(pop_oo);
            pair_new_reg <= PCW'(pop_pn) + PCW'(bnd_new);
            pair_old_reg <= PCW'(pop_po) + PCW'(bnd_old);
            old_top_reg  <= old2_reg[WORD_BITS-1];
            new_top_reg  <= new2_reg[WORD_BITS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_length_reg <= ACTIVE_LENGTH_RESET;
            word_reg          <= '0;
            wbase_reg         <= '0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            ones_reg          <= '0;
            pairs_reg         <= '0;
        end
        else
        begin
            if (active_length_we)
            begin
                active_length_reg <= active_length;
            end
            if (cmd.load)
            begin
                word_reg  <= '0;
                wbase_reg <= '0;
            end
            else if (cmd.clear_step || cmd.walk_step)
            begin
                word_reg  <= word_reg + AW'(1);
                wbase_reg <= wbase_reg + EW'(WORD_BITS);
            end
            v1_reg <= cmd.walk_step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg)
            begin
                ones_reg  <= ones_reg + CW'(ones_new_reg) - CW'(ones_old_reg);
                pairs_reg <= pairs_reg + CW'(pair_new_reg) - CW'(pair_old_reg);
            end
        end
    end

    logic [RW-1:0] runs;
    assign runs      = RW'(ones_reg) - RW'(pairs_reg);
    assign run_count = runs[RUN_W-1:0];

    always_comb
    begin
        status.clear_last  = (word_reg == AW'(NWORDS - 1));
        status.range_empty = empty_reg;
        status.walk_last   = (word_reg == AW'(NWORDS - 1)) || (wbase_reg > last_reg);
        status.pipe_busy   = v1_reg || v2_reg || v3_reg;
    end

endmodule

### rtl/core/bitmap_range_fill_run_counter.sv
// Top level of the bitmap range fill run counter: controller plus datapath.
// Depends on bmrf_pkg, bmrf_ctrl, bmrf_datapath and the assertion macro header.
//
// Usage. A fill is started by holding start high with first_index, last_index
// and fill_value; it is taken at a rising edge where busy is low. The block
// writes fill_value over first_index..last_index (last_index clamped to the
// active length) and reports the number of runs of ones in the whole bitmap.
// The result beat appears on run_count with done high for exactly one cycle;
// the receiver cannot stall it and must take it in that cycle.
// Walk: the walker visits words from 0 up to the word after the last one in
// range, or up to the last word of the map, one memory read-modify-write per
// cycle; an empty range skips the walk. Each word passes through the memory
// read, the fill and write-back, the popcount registers and the running
// totals; done waits until all of them have drained. active_length is
// written with active_length_we; write it only while busy is low and no fill
// is in flight.
// Reset: the totals clear at once, then a clearing pass zeroes all NWORDS
// words of the bitmap (16 by default), one word a cycle, with busy held high.
`include "bitmap_range_fill_run_counter_macros.svh"

module bitmap_range_fill_run_counter #(
    parameter int BITS      = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bmrf_pkg::IDX_W-1:0]   first_index,
    input  logic [bmrf_pkg::IDX_W-1:0]   last_index,
    input  logic                         fill_value,
    output logic                         done,
    output logic [bmrf_pkg::RUN_W-1:0]   run_count,
    input  logic                         active_length_we,
    input  logic [bmrf_pkg::CFG_W-1:0]   active_length
);
    import bmrf_pkg::*;

    bmrf_cmd_t    cmd;
    bmrf_status_t status;

    bmrf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bmrf_datapath #(
        .BITS      (BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .active_length_we (active_length_we),
        .active_length    (active_length),
        .first_index      (first_index),
        .last_index       (last_index),
        .fill_value       (fill_value),
        .run_count        (run_count)
    );

    // An accepted beat keeps the block busy until its result is out.
    `BMRF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // The result strobe lasts one cycle.
    `BMRF_ASSERT_NEXT(a_done_pulse, done, !done)
    // The result is shown only after the count pipeline has drained.
    `BMRF_ASSERT_IMPL(a_done_drained, done, !status.pipe_busy)
    // A new fill never starts on top of words still in the pipeline.
    `BMRF_ASSERT_IMPL(a_load_clean, cmd.load, !status.pipe_busy && !cmd.walk_step)

endmodule

### tb/tb_bitmap_range_fill_run_counter.sv
`timescale 1ns / 100ps
// Testbench for bitmap_range_fill_run_counter: directed and random range fills
// under many active lengths, each result checked against a bit-level copy of the map.
// Depends on bmrf_pkg and the RTL top level bitmap_range_fill_run_counter.

module tb_bitmap_range_fill_run_counter;
    import bmrf_pkg::*;

    localparam int MAP_BITS        = 1024;
    localparam int WORD_SZ         = 64;
    localparam int FILLS_PER_PHASE = 110;
    localparam int LENGTH_PHASES   = 13;
    localparam int SETTLE_CYCLES   = 30;
    localparam int MAX_GAP         = 16;

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        logic             value;
    } fill_t;

    // Keeps a plain bit array of the map and recounts the runs after every fill.
    class run_scoreboard;
        bit [MAP_BITS-1:0] map_bits;
        logic [CFG_W-1:0]  length_reg;
        logic [RUN_W-1:0]  run_q[$];
        int                errors;
        int                fills;
        int                empty_fills;
        int                compared;

        function new();
            map_bits    = '0;
            length_reg  = ACTIVE_LENGTH_RESET;
            errors      = 0;
            fills       = 0;
            empty_fills = 0;
            compared    = 0;
        endfunction

        function int usable_length();
            if (length_reg == 0)
                return 1;
            if (length_reg > MAP_BITS)
                return MAP_BITS;
            return int'(length_reg);
        endfunction

        function void note_fill(int first, int last, bit value);
            int i;
            int runs;
            if (last > usable_length() - 1)
                last = usable_length() - 1;
            fills++;
            if (first > last)
                empty_fills++;
            else
                for (i = first; i <= last; i++)
                    map_bits[i] = value;
            runs = 0;
            for (i = 0; i < MAP_BITS; i++)
                if (map_bits[i] && (i == 0 || !map_bits[i-1]))
                    runs++;
            run_q = {run_q, runs[RUN_W-1:0]};
        endfunction

        function void check_run(logic [RUN_W-1:0] got);
            logic [RUN_W-1:0] want;
            if (run_q.size() == 0)
            begin
                $display("%0t: run_count beat with no fill outstanding, expected none, got %0d",
                         $time, got);
                errors++;
                return;
            end
            want = run_q.pop_front();
            compared++;
            if (got !== want)
            begin
                $display("%0t: run_count mismatch, expected %0d, got %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
    logic             fill_value;
    logic             done;
    logic [RUN_W-1:0] run_count;
    logic             active_length_we;
    logic [CFG_W-1:0] active_length;

    run_scoreboard sb;
    bit            steady;
    int            phases;

    bitmap_range_fill_run_counter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .first_index      (first_index),
        .last_index       (last_index),
        .fill_value       (fill_value),
        .done             (done),
        .run_count        (run_count),
        .active_length_we (active_length_we),
        .active_length    (active_length)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_run(run_count);
    end

    function int draw_gap();
        if (steady)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Called at a rising edge; start stays high when the next beat follows at once.
    task automatic send_fill(input int first, input int last, input bit value);
        int gap;
        start       <= 1'b1;
        first_index <= first[IDX_W-1:0];
        last_index  <= last[IDX_W-1:0];
        fill_value  <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_fill(first, last, value);
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_fills();
        start <= 1'b0;
        while (sb.run_q.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] value);
        drain_fills();
        active_length_we <= 1'b1;
        active_length    <= value;
        @(posedge clk);
        active_length_we <= 1'b0;
        sb.length_reg = value;
        phases++;
    endtask

    // Mostly short fills inside the active length, plus word seams, tails that
    // run past the length, empty ranges and fully random fields.
    task automatic random_fill();
        int eff;
        int first;
        int last;
        int seam;
        int reach;
        eff = sb.usable_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                first = $urandom_range(0, eff - 1);
                last  = first + $urandom_range(0, 80);
            end
            4:
            begin
                seam  = $urandom_range(1, MAP_BITS / WORD_SZ - 1) * WORD_SZ;
                first = seam - $urandom_range(0, 2);
                last  = seam - 1 + $urandom_range(0, 2);
            end
            5:
            begin
                first = $urandom_range(0, MAP_BITS / 2 - 1);
                last  = $urandom_range(first, MAP_BITS - 1);
            end
            6:
            begin
                reach = (eff > 41) ? 40 : eff - 1;
                first = eff - 1 - $urandom_range(0, reach);
                last  = $urandom_range(first, MAP_BITS - 1);
            end
            7:
            begin
                if (eff < MAP_BITS && $urandom_range(0, 1))
                begin
                    first = $urandom_range(eff, MAP_BITS - 1);
                    last  = $urandom_range(0, MAP_BITS - 1);
                end
                else
                begin
                    last  = $urandom_range(0, MAP_BITS - 2);
                    first = $urandom_range(last + 1, MAP_BITS - 1);
                end
            end
            8:
            begin
                first = $urandom_range(0, MAP_BITS - 1);
                last  = $urandom_range(0, MAP_BITS - 1);
            end
            default:
            begin
                first = $urandom_range(0, MAP_BITS - 1);
                last  = first;
            end
        endcase
        if (last > MAP_BITS - 1)
            last = MAP_BITS - 1;
        send_fill(first, last, 1'($urandom_range(0, 1)));
    endtask

    fill_t directed_fills[20] = '{
        '{10'd0,    10'd0,    1'b1},
        '{10'd1023, 10'd1023, 1'b1},
        '{10'd0,    10'd1023, 1'b1},
        '{10'd63,   10'd64,   1'b0},
        '{10'd5,    10'd4,    1'b1},
        '{10'd1023, 10'd0,    1'b0},
        '{10'd0,    10'd1023, 1'b0},
        '{10'd62,   10'd62,   1'b1},
        '{10'd64,   10'd64,   1'b1},
        '{10'd63,   10'd63,   1'b1},
        '{10'd10,   10'd20,   1'b1},
        '{10'd15,   10'd15,   1'b0},
        '{10'd0,    10'd63,   1'b1},
        '{10'd64,   10'd127,  1'b1},
        '{10'd128,  10'd200,  1'b0},
        '{10'd1000, 10'd1023, 1'b1},
        '{10'd1022, 10'd1022, 1'b0},
        '{10'd511,  10'd512,  1'b1},
        '{10'd0,    10'd1023, 1'b0},
        '{10'd1,    10'd1022, 1'b1}
    };

    // Zero and values above the map size check the length saturation; shrinking
    // after full fills leaves ones beyond the length that must still be counted.
    int length_plan[12] = '{0, 1, 2, 63, 64, 65, 2047, 1025, 1023, 100, 640, 1024};

    initial
    begin
        int p;
        int n;
        sb               = new();
        phases           = 0;
        steady           = 1'b0;
        rst_n            = 1'b0;
        start            = 1'b0;
        first_index      = '0;
        last_index       = '0;
        fill_value       = 1'b0;
        active_length_we = 1'b0;
        active_length    = ACTIVE_LENGTH_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_fills[i])
            send_fill(int'(directed_fills[i].first), int'(directed_fills[i].last),
                      directed_fills[i].value);

        for (p = 0; p < LENGTH_PHASES; p++)
        begin
            if (p < 12)
                write_length(CFG_W'(length_plan[p]));
            else
                write_length(CFG_W'($urandom_range(1, 1100)));
            steady = ($urandom_range(0, 3) == 0);
            for (n = 0; n < FILLS_PER_PHASE; n++)
                random_fill();
        end

        drain_fills();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d fills (%0d empty after clamping) across %0d length settings.",
                 sb.fills, sb.empty_fills, phases);
        $display("Compared %0d run counts with %0d mismatches.", sb.compared, sb.errors);
        if (sb.errors == 0 && sb.run_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bmrf_pkg.sv
rtl/core/bmrf_ctrl.sv
rtl/core/bmrf_datapath.sv
rtl/core/bitmap_range_fill_run_counter.sv
tb/tb_bitmap_range_fill_run_counter.sv
